// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the layer blend RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lpab_pkg.sv =====
// Types and constants for the layer pixel alpha blend pipeline.
// No dependencies; imported by every lpab module.
package lpab_pkg;

   localparam int COORD_W     = 12;
   localparam int CFG_W       = 13;
   localparam int POS_W       = 14;
   localparam int OPAC_W      = 9;
   localparam int CHAN_W      = 8;
   localparam int WEIGHT_W    = 16;
   localparam int PROD_W      = 24;
   localparam int INDEX_W     = 24;
   localparam int NUM_CHAN    = 3;
   localparam int NUM_STAGES  = 4;
   localparam int CSR_INDEX_W = 3;

   localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 16'd65280;  // 255 * 256
   localparam logic [OPAC_W-1:0]   OPACITY_ONE = 9'd256;
   localparam logic [CHAN_W-1:0]   CHAN_MAX    = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_SHIFT      = 3'd0,
      CSR_Y_SHIFT      = 3'd1,
      CSR_FRAME_WIDTH  = 3'd2,
      CSR_FRAME_HEIGHT = 3'd3,
      CSR_OPACITY      = 3'd4
   } csr_index_type;

   // Config as seen by the datapath: sizes and opacity already clamped.
   typedef struct packed {
      logic [CFG_W-1:0]  x_shift;
      logic [CFG_W-1:0]  y_shift;
      logic [CFG_W-1:0]  frame_width;
      logic [CFG_W-1:0]  frame_height;
      logic [OPAC_W-1:0] opacity;
   } cfg_type;

   // Lane order: blue, green, red.
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_type;

   // Per-stage load enables from the valid/stall chain.
   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctl_type;

endpackage

// ===== rtl/core/lpab_csr.sv =====
// Configuration registers of the layer blend, with size and opacity clamping on write.
// Depends on lpab_pkg.
module lpab_csr import lpab_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int lim);
      if (int'(v) > lim) begin
         return CFG_W'(lim);
      end
      return v;
   endfunction

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_X_SHIFT:      cfg_in.x_shift      = csr_wdata;
            CSR_Y_SHIFT:      cfg_in.y_shift      = csr_wdata;
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = clamp_dim(csr_wdata, MAX_WIDTH);
            CSR_FRAME_HEIGHT: cfg_in.frame_height = clamp_dim(csr_wdata, MAX_HEIGHT);
            CSR_OPACITY: begin
               cfg_in.opacity = (csr_wdata[OPAC_W-1:0] > OPACITY_ONE) ?
                                OPACITY_ONE : csr_wdata[OPAC_W-1:0];
            end
            default: ;  // unmapped index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_shift      <= '0;
         cfg_ff.y_shift      <= '0;
         cfg_ff.frame_width  <= CFG_W'(1);
         cfg_ff.frame_height <= CFG_W'(1);
         cfg_ff.opacity      <= OPACITY_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/lpab_coord.sv =====
// Coordinate path: layer offset, frame clip and linear index, four stages.
// Depends on lpab_pkg.
module lpab_coord import lpab_pkg::*; (
   input  logic               clock,
   input  pipe_ctl_type       ctl,
   input  cfg_type            cfg,
   input  logic [COORD_W-1:0] src_col,
   input  logic [COORD_W-1:0] src_row,
   output logic               write_enable,
   output logic [INDEX_W-1:0] dst_index
);

   // stage 0: signed frame position
   logic [POS_W-1:0] dx_in, dy_in, dx_ff, dy_ff;
   // stage 1: clip and row base
   logic                 inside1_in, inside1_ff;
   logic [2*CFG_W-1:0]   prod_full;
   logic [INDEX_W-1:0]   prod_ff;
   logic [CFG_W-1:0]     dx1_ff;
   // stage 2: index
   logic                 inside2_ff;
   logic [INDEX_W-1:0]   idx_in, idx_ff;
   // stage 3: output
   logic                 we_ff;
   logic [INDEX_W-1:0]   index_ff;

   assign dx_in = {cfg.x_shift[CFG_W-1], cfg.x_shift} + {{(POS_W-COORD_W){1'b0}}, src_col};
   assign dy_in = {cfg.y_shift[CFG_W-1], cfg.y_shift} + {{(POS_W-COORD_W){1'b0}}, src_row};

   assign inside1_in = !dx_ff[POS_W-1] && !dy_ff[POS_W-1] &&
                       (dx_ff[CFG_W-1:0] < cfg.frame_width) &&
                       (dy_ff[CFG_W-1:0] < cfg.frame_height);
   assign prod_full  = dy_ff[CFG_W-1:0] * cfg.frame_width;

   assign idx_in = prod_ff + {{(INDEX_W-CFG_W){1'b0}}, dx1_ff};

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (ctl.en[1]) begin
         inside1_ff <= inside1_in;
         prod_ff    <= prod_full[INDEX_W-1:0];
         dx1_ff     <= dx_ff[CFG_W-1:0];
      end
      if (ctl.en[2]) begin
         inside2_ff <= inside1_ff;
         idx_ff     <= idx_in;
      end
      if (ctl.en[3]) begin
         we_ff    <= inside2_ff;
         index_ff <= inside2_ff ? idx_ff : '0;
      end
   end

   assign write_enable = we_ff;
   assign dst_index    = index_ff;

endmodule

// ===== rtl/core/lpab_mix.sv =====
// Color path: weight, per-lane products, and divide by 65280 over four stages.
// Depends on lpab_pkg.
module lpab_mix import lpab_pkg::*; (
   input  logic              clock,
   input  pipe_ctl_type      ctl,
   input  logic [OPAC_W-1:0] opacity,
   input  logic [CHAN_W-1:0] src_alpha,
   input  pixel_type         src_pix,
   input  pixel_type         dst_pix,
   output pixel_type         out_pix
);

   localparam int HI_W = PROD_W - CHAN_W;  // acc / 256

   logic [CHAN_W+OPAC_W-1:0]            w_full;
   logic [WEIGHT_W-1:0]                 w_ff, inv_w;
   pixel_type                           src0_ff, dst0_ff;
   logic [NUM_CHAN-1:0][PROD_W-1:0]     pd_in, ps_in, pd_ff, ps_ff;
   logic [NUM_CHAN-1:0][PROD_W:0]       acc;
   logic [NUM_CHAN-1:0][HI_W-1:0]       hi_in, hi_ff, est, rem;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]     q0_ff;
   pixel_type                           q_in, out_ff;

   assign w_full = src_alpha * opacity;
   assign inv_w  = FULL_WEIGHT - w_ff;

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         pd_in[i] = PROD_W'(dst0_ff[i]) * PROD_W'(inv_w);
         ps_in[i] = PROD_W'(src0_ff[i]) * PROD_W'(w_ff);
         acc[i]   = {1'b0, pd_ff[i]} + {1'b0, ps_ff[i]};
         hi_in[i] = acc[i][PROD_W-1:CHAN_W];
         // (hi + hi/256)/256 undershoots hi/255 by at most one
         est[i]   = hi_in[i] + (hi_in[i] >> CHAN_W);
         rem[i]   = hi_ff[i] - ({q0_ff[i], {CHAN_W{1'b0}}} - HI_W'(q0_ff[i]));
         q_in[i]  = q0_ff[i] + CHAN_W'(rem[i] >= HI_W'(CHAN_MAX));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         w_ff    <= w_full[WEIGHT_W-1:0];
         src0_ff <= src_pix;
         dst0_ff <= dst_pix;
      end
      if (ctl.en[1]) begin
         pd_ff <= pd_in;
         ps_ff <= ps_in;
      end
      if (ctl.en[2]) begin
         hi_ff <= hi_in;
         for (int i = 0; i < NUM_CHAN; i++) begin
            q0_ff[i] <= est[i][HI_W-1:CHAN_W];
         end
      end
      if (ctl.en[3]) begin
         out_ff <= q_in;
      end
   end

   assign out_pix = out_ff;

endmodule

// ===== rtl/core/layer_pixel_alpha_blend.sv =====
// Layer pixel alpha blend: offset, clip, linear index and opacity-weighted mix.
// Pipeline: registered stages for weight, lane products and row base, index and
// estimate, and the divide-by-65280 correction, from request transfer to result.
// Throughput: one pixel per cycle while rsp_stall stays low; a held result backs
// up the stages and raises req_stall once every stage is full.
// Reset: pipeline valids cleared; registers to x/y offset 0, frame 1x1, opacity 256.
`include "assert_macros.svh"

module layer_pixel_alpha_blend import lpab_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COORD_W-1:0]     req_src_col,
   input  logic [COORD_W-1:0]     req_src_row,
   input  logic [CHAN_W-1:0]      req_src_blue,
   input  logic [CHAN_W-1:0]      req_src_green,
   input  logic [CHAN_W-1:0]      req_src_red,
   input  logic [CHAN_W-1:0]      req_src_alpha,
   input  logic [CHAN_W-1:0]      req_dst_blue,
   input  logic [CHAN_W-1:0]      req_dst_green,
   input  logic [CHAN_W-1:0]      req_dst_red,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_write_enable,
   output logic [INDEX_W-1:0]     rsp_dst_index,
   output logic [CHAN_W-1:0]      rsp_out_blue,
   output logic [CHAN_W-1:0]      rsp_out_green,
   output logic [CHAN_W-1:0]      rsp_out_red,
   output logic [CHAN_W-1:0]      rsp_out_alpha,
   // config write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   cfg_type               cfg;
   pipe_ctl_type          ctl;
   logic [NUM_STAGES-1:0] valid_ff, valid_in, en;
   pixel_type             src_pix, dst_pix, out_pix;

   // Register writes are always taken; the host must write only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   lpab_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Stall chain: a stage loads when it is empty or the one after it moves.
   // Bubbles collapse, so a new pixel enters while a finished one waits at
   // the output as long as any stage is free.
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES-2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign ctl.en    = en;
   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   lpab_coord u_coord (
      .clock        (clock),
      .ctl          (ctl),
      .cfg          (cfg),
      .src_col      (req_src_col),
      .src_row      (req_src_row),
      .write_enable (rsp_write_enable),
      .dst_index    (rsp_dst_index)
   );

   // lanes: 0 blue, 1 green, 2 red
   assign src_pix = {req_src_red, req_src_green, req_src_blue};
   assign dst_pix = {req_dst_red, req_dst_green, req_dst_blue};

   lpab_mix u_mix (
      .clock     (clock),
      .ctl       (ctl),
      .opacity   (cfg.opacity),
      .src_alpha (req_src_alpha),
      .src_pix   (src_pix),
      .dst_pix   (dst_pix),
      .out_pix   (out_pix)
   );

   assign rsp_valid     = valid_ff[NUM_STAGES-1];
   assign rsp_out_blue  = out_pix[0];
   assign rsp_out_green = out_pix[1];
   assign rsp_out_red   = out_pix[2];
   assign rsp_out_alpha = CHAN_MAX;

   // Request side stalls only with every stage full and the output held.
   `ASSERT_IMPL(a_stall_only_full, clock, reset, req_stall, (&valid_ff) && rsp_stall, "request stalled with a free stage")
   // Clipped pixels carry a zero index.
   `ASSERT_IMPL(a_clip_zero_index, clock, reset, rsp_valid && !rsp_write_enable, rsp_dst_index == '0, "clipped result with nonzero index")
   // Unstalled pipeline delivers an accepted pixel once it has passed every stage.
   `ASSERT_NEXT(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall, rsp_valid, "pixel missing at output after four cycles")
   // Stored opacity never exceeds one.
   `ASSERT_IMPL(a_opacity_sat, clock, reset, 1'b1, cfg.opacity <= OPACITY_ONE, "opacity above saturation")

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for layer_pixel_alpha_blend: clip, linear index and opacity blend.
// Needs lpab_pkg and the block's RTL; predicts every result in SystemVerilog.
`timescale 1ns / 1ps

module testbench;
   import lpab_pkg::*;

   // Frame clamps match the block's parameters as instantiated below.
   localparam int MAX_W        = 4096;
   localparam int MAX_H        = 4096;
   localparam int COORD_MAX    = (1 << COORD_W) - 1;
   localparam int DRAIN_CYCLES = NUM_STAGES + 4;
   localparam int RANDOM_ROUNDS = 8;
   localparam int ROUND_PIXELS  = 104;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 40;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH
   } flow_mode_type;

   // One pixel as offered on the request side.
   typedef struct {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [CHAN_W-1:0]  src_b, src_g, src_r, src_a;
      logic [CHAN_W-1:0]  dst_b, dst_g, dst_r;
   } layer_pixel_type;

   // One blended pixel as seen on the result side.
   typedef struct {
      logic               write_en;
      logic [INDEX_W-1:0] index;
      logic [CHAN_W-1:0]  blue, green, red, alpha;
   } blended_pixel_type;

   // Bench copy of the layer registers, raw as written.
   typedef struct {
      logic signed [CFG_W-1:0] x_off;
      logic signed [CFG_W-1:0] y_off;
      logic [CFG_W-1:0]        width;
      logic [CFG_W-1:0]        height;
      logic [OPAC_W-1:0]       opacity;
   } layer_setup_type;

   typedef struct {
      logic [CSR_INDEX_W-1:0] index;
      logic [CFG_W-1:0]       data;
   } reg_write_type;

   localparam layer_setup_type SETUP_AT_RESET = '{
      x_off: '0, y_off: '0, width: CFG_W'(1), height: CFG_W'(1), opacity: OPACITY_ONE
   };

   // ---------------------------------------------------------------
   // Clock, reset and block inputs (all known from time zero)
   // ---------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic [COORD_W-1:0]     req_src_col   = '0;
   logic [COORD_W-1:0]     req_src_row   = '0;
   logic [CHAN_W-1:0]      req_src_blue  = '0;
   logic [CHAN_W-1:0]      req_src_green = '0;
   logic [CHAN_W-1:0]      req_src_red   = '0;
   logic [CHAN_W-1:0]      req_src_alpha = '0;
   logic [CHAN_W-1:0]      req_dst_blue  = '0;
   logic [CHAN_W-1:0]      req_dst_green = '0;
   logic [CHAN_W-1:0]      req_dst_red   = '0;

   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic                   rsp_write_enable;
   logic [INDEX_W-1:0]     rsp_dst_index;
   logic [CHAN_W-1:0]      rsp_out_blue;
   logic [CHAN_W-1:0]      rsp_out_green;
   logic [CHAN_W-1:0]      rsp_out_red;
   logic [CHAN_W-1:0]      rsp_out_alpha;

   logic                   csr_valid     = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CFG_W-1:0]       csr_wdata     = '0;

   // ---------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------
   layer_pixel_type   pixels_to_send[$];     // filled by the stimulus, drained by the driver
   blended_pixel_type blends_due[$];         // predictions, oldest first
   reg_write_type     reg_writes_to_send[$];
   layer_setup_type   layer_setup = SETUP_AT_RESET;

   int sender_gap_pct     = 0;
   int receiver_stall_pct = 0;
   int blend_errors       = 0;
   int pixels_accepted    = 0;
   int results_seen       = 0;
   int results_written    = 0;
   int setups_applied     = 0;
   int cycle_count        = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------
   // DUT
   // ---------------------------------------------------------------
   layer_pixel_alpha_blend #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_src_col      (req_src_col),
      .req_src_row      (req_src_row),
      .req_src_blue     (req_src_blue),
      .req_src_green    (req_src_green),
      .req_src_red      (req_src_red),
      .req_src_alpha    (req_src_alpha),
      .req_dst_blue     (req_dst_blue),
      .req_dst_green    (req_dst_green),
      .req_dst_red      (req_dst_red),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_enable (rsp_write_enable),
      .rsp_dst_index    (rsp_dst_index),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_alpha    (rsp_out_alpha),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // Weighted mix of one lane; full weight is 255*256.
   function automatic logic [CHAN_W-1:0] mix_lane(logic [CHAN_W-1:0] dst_c,
                                                  logic [CHAN_W-1:0] src_c,
                                                  int unsigned weight);
      int unsigned full;
      int unsigned acc;
      full = FULL_WEIGHT;
      acc  = dst_c * (full - weight) + src_c * weight;
      return CHAN_W'(acc / full);
   endfunction

   function automatic blended_pixel_type blend_pixel(layer_pixel_type px, layer_setup_type s);
      int unsigned       fw, fh, op, weight;
      int                dx, dy;
      logic              in_frame;
      blended_pixel_type r;
      // oversize frames clamp to the maximum, opacity saturates at 1.0
      fw     = (s.width > MAX_W) ? MAX_W : s.width;
      fh     = (s.height > MAX_H) ? MAX_H : s.height;
      op     = (s.opacity > OPACITY_ONE) ? OPACITY_ONE : s.opacity;
      dx     = int'(s.x_off) + int'(px.col);
      dy     = int'(s.y_off) + int'(px.row);
      // zero width or height fails the upper bound for every position
      in_frame = (dx >= 0) && (dy >= 0) && (dx < int'(fw)) && (dy < int'(fh));
      weight = px.src_a * op;
      r.write_en = in_frame;
      r.index    = in_frame ? INDEX_W'(dy * fw + dx) : '0;
      // clipped pixels still carry the blend
      r.blue     = mix_lane(px.dst_b, px.src_b, weight);
      r.green    = mix_lane(px.dst_g, px.src_g, weight);
      r.red      = mix_lane(px.dst_r, px.src_r, weight);
      r.alpha    = CHAN_MAX;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Error reporting: one line per mismatch, printing capped
   // ---------------------------------------------------------------
   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      blend_errors++;
      if (blend_errors <= PRINT_LIMIT)
         $display("ERROR %0t ns result %0d: %s expected %0d got %0d",
                  $time, results_seen, what, want, got);
   endtask

   // ---------------------------------------------------------------
   // Register write driver. Bench copy follows each accepted transfer;
   // spare indexes fall through and change nothing.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : reg_writer
      reg_write_type wr;
      if (reset) begin
         csr_valid   <= 1'b0;
         layer_setup <= SETUP_AT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_X_SHIFT:      layer_setup.x_off   <= csr_wdata;
               CSR_Y_SHIFT:      layer_setup.y_off   <= csr_wdata;
               CSR_FRAME_WIDTH:  layer_setup.width   <= csr_wdata;
               CSR_FRAME_HEIGHT: layer_setup.height  <= csr_wdata;
               CSR_OPACITY:      layer_setup.opacity <= csr_wdata[OPAC_W-1:0];
               default: ;
            endcase
         end
         if (!csr_valid || csr_ready) begin
            if (reg_writes_to_send.size() > 0) begin
               wr = reg_writes_to_send.pop_front();
               csr_valid <= 1'b1;
               csr_index <= wr.index;
               csr_wdata <= wr.data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Pixel driver. On each accepted transfer the prediction is queued;
   // a new pixel is offered only once the bus is free, with random gaps.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : pixel_driver
      layer_pixel_type on_bus;
      layer_pixel_type next_px;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            on_bus = '{req_src_col, req_src_row, req_src_blue, req_src_green, req_src_red,
                       req_src_alpha, req_dst_blue, req_dst_green, req_dst_red};
            blends_due = {blends_due, blend_pixel(on_bus, layer_setup)};
            pixels_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pixels_to_send.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
               next_px = pixels_to_send.pop_front();
               req_valid     <= 1'b1;
               req_src_col   <= next_px.col;
               req_src_row   <= next_px.row;
               req_src_blue  <= next_px.src_b;
               req_src_green <= next_px.src_g;
               req_src_red   <= next_px.src_r;
               req_src_alpha <= next_px.src_a;
               req_dst_blue  <= next_px.dst_b;
               req_dst_green <= next_px.dst_g;
               req_dst_red   <= next_px.dst_r;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result monitor and receiver stall
   // ---------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      blended_pixel_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_write_enable === 1'b1)
               results_written++;
            if (blends_due.size() == 0) begin
               report_mismatch("result with nothing pending, index", 0, rsp_dst_index);
            end else begin
               want = blends_due.pop_front();
               if (rsp_write_enable !== want.write_en)
                  report_mismatch("write_enable", want.write_en, rsp_write_enable);
               if (rsp_dst_index !== want.index)
                  report_mismatch("dst_index", want.index, rsp_dst_index);
               if (rsp_out_blue !== want.blue)
                  report_mismatch("out_blue", want.blue, rsp_out_blue);
               if (rsp_out_green !== want.green)
                  report_mismatch("out_green", want.green, rsp_out_green);
               if (rsp_out_red !== want.red)
                  report_mismatch("out_red", want.red, rsp_out_red);
               if (rsp_out_alpha !== want.alpha)
                  report_mismatch("out_alpha", want.alpha, rsp_out_alpha);
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                  blends_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers (all run from the negative edge)
   // ---------------------------------------------------------------

   // Wait for every pixel sent and every result back, then let the pipe settle.
   task automatic wait_idle();
      while (pixels_to_send.size() > 0 || req_valid || blends_due.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic flush_reg_writes();
      while (reg_writes_to_send.size() > 0 || csr_valid)
         @(negedge clock);
   endtask

   task automatic queue_reg_write(logic [CSR_INDEX_W-1:0] idx, int data);
      reg_write_type wr;
      wr.index = idx;
      wr.data  = CFG_W'(data);
      reg_writes_to_send = {reg_writes_to_send, wr};
   endtask

   task automatic apply_setup(int x_off, int y_off, int width, int height, int opacity);
      wait_idle();
      queue_reg_write(CSR_X_SHIFT, x_off);
      queue_reg_write(CSR_Y_SHIFT, y_off);
      queue_reg_write(CSR_FRAME_WIDTH, width);
      queue_reg_write(CSR_FRAME_HEIGHT, height);
      queue_reg_write(CSR_OPACITY, opacity);
      flush_reg_writes();
      @(negedge clock);
      setups_applied++;
   endtask

   task automatic set_flow(flow_mode_type mode);
      case (mode)
         FLOW_FREE:            begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
         FLOW_SENDER_GAPS:     begin sender_gap_pct = 66; receiver_stall_pct = 0;  end
         FLOW_RECEIVER_STALLS: begin sender_gap_pct = 0;  receiver_stall_pct = 66; end
         default:              begin sender_gap_pct = 21; receiver_stall_pct = 21; end
      endcase
   endtask

   task automatic push_pixel(int col, int row, int alpha, int sb, int sg, int sr,
                             int db, int dg, int dr);
      layer_pixel_type px;
      px.col   = COORD_W'(col);
      px.row   = COORD_W'(row);
      px.src_a = CHAN_W'(alpha);
      px.src_b = CHAN_W'(sb);
      px.src_g = CHAN_W'(sg);
      px.src_r = CHAN_W'(sr);
      px.dst_b = CHAN_W'(db);
      px.dst_g = CHAN_W'(dg);
      px.dst_r = CHAN_W'(dr);
      pixels_to_send = {pixels_to_send, px};
   endtask

   // Pick a layer coordinate that lands near the frame, edges included.
   function automatic int aim_coord(int offset, int extent, int fallback);
      int lo, hi;
      if (extent > MAX_W)
         extent = MAX_W;
      lo = -2 - offset;
      hi = extent + 1 - offset;
      if (lo < 0)
         lo = 0;
      if (hi > COORD_MAX)
         hi = COORD_MAX;
      if (lo > hi)
         return fallback;
      return $urandom_range(hi, lo);
   endfunction

   task automatic push_random(int count);
      int col, row, alpha, pick;
      repeat (count) begin
         col = $urandom_range(COORD_MAX);
         row = $urandom_range(COORD_MAX);
         // most pixels aimed at the frame, the rest anywhere
         if ($urandom_range(99) < 80) begin
            col = aim_coord(int'(layer_setup.x_off), int'(layer_setup.width), col);
            row = aim_coord(int'(layer_setup.y_off), int'(layer_setup.height), row);
         end
         pick = $urandom_range(99);
         if (pick < 15)
            alpha = 0;
         else if (pick < 30)
            alpha = CHAN_MAX;
         else
            alpha = $urandom_range(CHAN_MAX);
         push_pixel(col, row, alpha,
                    $urandom_range(CHAN_MAX), $urandom_range(CHAN_MAX),
                    $urandom_range(CHAN_MAX), $urandom_range(CHAN_MAX),
                    $urandom_range(CHAN_MAX), $urandom_range(CHAN_MAX));
      end
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      @(negedge clock);
      while (reset)
         @(negedge clock);
      set_flow(FLOW_FREE);

      // Registers at their reset values: 1x1 frame at the origin, full opacity.
      push_pixel(0, 0, 255, 10, 20, 30, 200, 100, 50);
      push_pixel(1, 0, 128, 255, 0, 77, 0, 255, 99);
      push_pixel(0, 1, 0, 1, 2, 3, 4, 5, 6);

      // Small frame with a negative x shift: left, right and bottom edges from inside and outside.
      apply_setup(-3, 2, 10, 6, 256);
      push_pixel(0, 0, 255, 9, 9, 9, 1, 1, 1);          // left of frame
      push_pixel(3, 0, 255, 40, 50, 60, 70, 80, 90);    // left edge, inside
      push_pixel(12, 3, 128, 255, 128, 0, 0, 128, 255); // bottom-right corner
      push_pixel(13, 3, 200, 11, 22, 33, 44, 55, 66);   // right of frame
      push_pixel(3, 4, 200, 11, 22, 33, 44, 55, 66);    // below frame
      push_pixel(5, 1, 1, 255, 255, 255, 0, 0, 0);
      push_pixel(4, 2, 254, 255, 255, 255, 0, 0, 0);

      // Oversize width clamps to the maximum; opacity above one saturates.
      apply_setup(0, 0, (1 << CFG_W) - 1, MAX_H, (1 << OPAC_W) - 1);
      push_pixel(COORD_MAX, COORD_MAX, 255, 0, 0, 0, 255, 255, 255); // largest index
      push_pixel(COORD_MAX, 0, 100, 255, 0, 255, 0, 255, 0);
      push_pixel(0, COORD_MAX, 200, 17, 34, 51, 68, 85, 102);

      // Most negative offsets, zero width, zero opacity: destination passes through.
      apply_setup(-4096, -4096, 0, MAX_H, 0);
      push_pixel(COORD_MAX, COORD_MAX, 255, 255, 255, 255, 0, 0, 0);
      push_pixel(0, 0, 77, 200, 150, 100, 10, 20, 30);

      // Most positive offsets, zero height.
      apply_setup(4095, 4095, MAX_W, 0, 128);
      push_pixel(0, 0, 255, 255, 255, 255, 3, 4, 5);
      push_pixel(COORD_MAX, COORD_MAX, 90, 100, 110, 120, 130, 140, 150);

      // Writes to spare indexes must leave every register alone.
      apply_setup(0, 0, 16, 16, 128);
      queue_reg_write(CSR_INDEX_W'(int'(CSR_OPACITY) + 1), 0);
      queue_reg_write(CSR_INDEX_W'((1 << CSR_INDEX_W) - 1), (1 << CFG_W) - 1);
      flush_reg_writes();
      push_pixel(3, 2, 255, 240, 120, 60, 30, 15, 5);
      push_pixel(15, 15, 200, 0, 255, 0, 255, 0, 255);

      // Random rounds: a new setting each round, flow mode cycling.
      for (int rnd = 0; rnd < RANDOM_ROUNDS; rnd++) begin
         case (rnd)
            0: apply_setup(0, 0, 640, 480, 256);
            1: apply_setup(-37, 12, 100, 60, 255);
            2: apply_setup(300, -100, MAX_W, MAX_H, 300);
            4: apply_setup(4090, -4090, MAX_W, 16, 64);
            6: apply_setup(1, 1, 1, 1, 256);
            default: apply_setup($urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                                 $urandom_range(MAX_W, 0), $urandom_range(MAX_H, 0),
                                 $urandom_range((1 << OPAC_W) - 1));
         endcase
         set_flow(flow_mode_type'(rnd % 4));
         push_random(ROUND_PIXELS);
      end

      set_flow(FLOW_FREE);
      wait_idle();

      $display("Blended %0d pixels (%0d inside the frame) across %0d register settings",
               results_seen, results_written, setups_applied);
      $display("Offsets, clamped and zero frame sizes, saturated opacity and gap/stall mixes");
      if (blend_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", blend_errors);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lpab_pkg.sv
rtl/core/lpab_csr.sv
rtl/core/lpab_coord.sv
rtl/core/lpab_mix.sv
rtl/core/layer_pixel_alpha_blend.sv
verif/testbench.sv
